/* rtl/core/pcct_pkg.sv */
// pcct_pkg: shared types, constants and field layout of the poll change
// confirmation tracker. Used by every module of the block; no dependencies.
package pcct_pkg;

    localparam int MODE_BITS = 4;
    localparam int FREQ_BITS = 36;
    localparam int FUNC_BITS = 3;
    localparam int CNT_BITS  = 4;
    localparam int SEC_BITS  = 16;
    localparam int MS_BITS   = 26;

    // input word layout, lowest bit first
    localparam int IN_FREQ_LO  = 0;
    localparam int IN_TX_LO    = IN_FREQ_LO + FREQ_BITS;
    localparam int IN_MODE_LO  = IN_TX_LO + FREQ_BITS;
    localparam int IN_PTT      = IN_MODE_LO + MODE_BITS;
    localparam int IN_SPLIT    = IN_PTT + 1;
    localparam int IN_ONLINE   = IN_SPLIT + 1;
    localparam int IN_TRANS    = IN_ONLINE + 1;
    localparam int IN_USED     = IN_TRANS + 1;
    localparam int IN_DATA_BITS = ((IN_USED + 7) / 8) * 8;

    // output word layout, lowest bit first
    localparam int OUT_UPD      = 0;
    localparam int OUT_OFFL     = 1;
    localparam int OUT_TOL      = 2;
    localparam int OUT_EXTRA    = 3;
    localparam int OUT_FAST     = 4;
    localparam int OUT_MS_LO    = 5;
    localparam int OUT_USED     = OUT_MS_LO + MS_BITS;
    localparam int OUT_DATA_BITS = ((OUT_USED + 7) / 8) * 8;

    localparam logic [FUNC_BITS-1:0] FUNC_START     = 3'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_STOP      = 3'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_SET_FREQ  = 3'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_SET_TX    = 3'd3;
    localparam logic [FUNC_BITS-1:0] FUNC_SET_MODE  = 3'd4;
    localparam logic [FUNC_BITS-1:0] FUNC_SET_PTT   = 3'd5;
    localparam logic [FUNC_BITS-1:0] FUNC_POLL_OK   = 3'd6;
    localparam logic [FUNC_BITS-1:0] FUNC_POLL_FAIL = 3'd7;

    localparam logic [1:0] REG_POLL_SECONDS = 2'd0;
    localparam logic [1:0] REG_SETTLE_POLLS = 2'd1;
    localparam logic [1:0] REG_GENERIC_TOL  = 2'd2;
    localparam logic [1:0] REG_TRANSIENT_TOL = 2'd3;

    localparam logic [SEC_BITS-1:0] POLL_SECONDS_RST = 16'd1;
    localparam logic [CNT_BITS-1:0] SETTLE_POLLS_RST = 4'd3;
    localparam logic [CNT_BITS-1:0] GENERIC_TOL_RST  = 4'd3;
    localparam logic [CNT_BITS-1:0] TRANSIENT_TOL_RST = 4'd8;

    localparam logic [9:0]         MS_PER_SEC = 10'd1000;
    localparam logic [MS_BITS-1:0] FAST_MIN_MS = 26'd250;

    typedef enum logic [7:0] {
        K_START     = 8'b0000_0001,
        K_STOP      = 8'b0000_0010,
        K_SET_FREQ  = 8'b0000_0100,
        K_SET_TX    = 8'b0000_1000,
        K_SET_MODE  = 8'b0001_0000,
        K_SET_PTT   = 8'b0010_0000,
        K_POLL_OK   = 8'b0100_0000,
        K_POLL_FAIL = 8'b1000_0000
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [FREQ_BITS-1:0] freq;
        logic [FREQ_BITS-1:0] tx_freq;
        logic [MODE_BITS-1:0] mode;
        logic                 ptt;
        logic                 split;
        logic                 online;
        logic                 transient;
    } t_item;

    typedef struct packed {
        logic [FREQ_BITS-1:0] freq;
        logic [FREQ_BITS-1:0] tx_freq;
        logic [MODE_BITS-1:0] mode;
        logic                 ptt;
        logic                 split;
        logic                 online;
    } t_view;

    typedef struct packed {
        logic [SEC_BITS-1:0] poll_seconds;
        logic [CNT_BITS-1:0] settle_polls;
        logic [CNT_BITS-1:0] generic_tol;
        logic [CNT_BITS-1:0] transient_tol;
    } t_cfg;

    typedef struct packed {
        logic                upd;
        logic                offl;
        logic                tol;
        logic                extra;
        logic                fast;
        logic [MS_BITS-1:0]  ms;
    } t_result;

endpackage

/* rtl/core/pcct_front.sv */
// pcct_front: accepts input words, decodes the function code into an event
// kind and holds the unpacked item for the queue. Depends on pcct_pkg.
module pcct_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // freq, tx_freq, mode, ptt, split, online, transient
    input  logic [pcct_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    // func
    input  logic [pcct_pkg::FUNC_BITS-1:0]      s_axis_tuser,
    output logic                                o_valid,
    input  logic                                i_ready,
    output pcct_pkg::t_item                     o_item
);

    logic            r_valid;
    pcct_pkg::t_item r_item;
    pcct_pkg::t_item n_item;

    assign s_axis_tready = !r_valid || i_ready;
    assign o_valid       = r_valid;
    assign o_item        = r_item;

    always_comb begin
        n_item.freq      = s_axis_tdata[pcct_pkg::IN_FREQ_LO +: pcct_pkg::FREQ_BITS];
        n_item.tx_freq   = s_axis_tdata[pcct_pkg::IN_TX_LO +: pcct_pkg::FREQ_BITS];
        n_item.mode      = s_axis_tdata[pcct_pkg::IN_MODE_LO +: pcct_pkg::MODE_BITS];
        n_item.ptt       = s_axis_tdata[pcct_pkg::IN_PTT];
        n_item.split     = s_axis_tdata[pcct_pkg::IN_SPLIT];
        n_item.online    = s_axis_tdata[pcct_pkg::IN_ONLINE];
        n_item.transient = s_axis_tdata[pcct_pkg::IN_TRANS];
        case (s_axis_tuser)
            pcct_pkg::FUNC_START:    n_item.kind = pcct_pkg::K_START;
            pcct_pkg::FUNC_STOP:     n_item.kind = pcct_pkg::K_STOP;
            pcct_pkg::FUNC_SET_FREQ: n_item.kind = pcct_pkg::K_SET_FREQ;
            pcct_pkg::FUNC_SET_TX:   n_item.kind = pcct_pkg::K_SET_TX;
            pcct_pkg::FUNC_SET_MODE: n_item.kind = pcct_pkg::K_SET_MODE;
            pcct_pkg::FUNC_SET_PTT:  n_item.kind = pcct_pkg::K_SET_PTT;
            pcct_pkg::FUNC_POLL_OK:  n_item.kind = pcct_pkg::K_POLL_OK;
            default:                 n_item.kind = pcct_pkg::K_POLL_FAIL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item <= n_item;
        end
    end

endmodule

/* rtl/core/pcct_queue.sv */
// pcct_queue: two-entry queue of decoded items between front and back.
// Depends on pcct_pkg.
module pcct_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_ready,
    input  pcct_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_pop,
    output pcct_pkg::t_item o_item
);

    pcct_pkg::t_item r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            do_push;
    logic            do_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* rtl/core/pcct_back.sv */
// pcct_back: expected/reported state, settle countdown, failure counting and
// poll interval; registers one result word. Depends on pcct_pkg.
module pcct_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pcct_pkg::t_cfg                     i_cfg,
    input  logic                               i_valid,
    output logic                               o_pop,
    input  pcct_pkg::t_item                    i_item,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // update_signal, offline_report, failure_tolerated, extra_polls,
    // fast_mode, interval_ms
    output logic [pcct_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

    pcct_pkg::t_view   r_want, n_want;
    pcct_pkg::t_view   r_told, n_told;
    logic [pcct_pkg::CNT_BITS-1:0] r_settle, n_settle;
    logic [pcct_pkg::CNT_BITS-1:0] r_fail, n_fail;
    logic              r_halted, n_halted;
    logic              r_fast, n_fast;
    logic              r_out_valid;
    pcct_pkg::t_result r_out, n_out;

    pcct_pkg::t_view   got;
    logic [pcct_pkg::CNT_BITS-1:0] settle_dec;
    logic [pcct_pkg::CNT_BITS-1:0] fail_inc;
    logic [pcct_pkg::CNT_BITS-1:0] limit;
    logic              fire;
    logic [pcct_pkg::SEC_BITS-1:0] secs;
    logic [pcct_pkg::MS_BITS-1:0]  base_ms;
    logic [pcct_pkg::MS_BITS-1:0]  quarter_ms;

    assign o_pop         = i_valid && (!r_out_valid || m_axis_tready);
    assign m_axis_tvalid = r_out_valid;

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[pcct_pkg::OUT_UPD]   = r_out.upd;
        m_axis_tdata[pcct_pkg::OUT_OFFL]  = r_out.offl;
        m_axis_tdata[pcct_pkg::OUT_TOL]   = r_out.tol;
        m_axis_tdata[pcct_pkg::OUT_EXTRA] = r_out.extra;
        m_axis_tdata[pcct_pkg::OUT_FAST]  = r_out.fast;
        m_axis_tdata[pcct_pkg::OUT_MS_LO +: pcct_pkg::MS_BITS] = r_out.ms;
    end

    assign got.freq    = i_item.freq;
    assign got.tx_freq = i_item.tx_freq;
    assign got.mode    = i_item.mode;
    assign got.ptt     = i_item.ptt;
    assign got.split   = i_item.split;
    assign got.online  = i_item.online;

    assign settle_dec = r_settle - pcct_pkg::CNT_BITS'(1);
    assign fail_inc   = r_fail + pcct_pkg::CNT_BITS'(1);
    assign limit      = i_item.transient ? i_cfg.transient_tol : i_cfg.generic_tol;

    // zero seconds runs as one
    assign secs       = (i_cfg.poll_seconds == '0) ? pcct_pkg::SEC_BITS'(1)
                                                   : i_cfg.poll_seconds;
    assign base_ms    = pcct_pkg::MS_BITS'(secs) * pcct_pkg::MS_BITS'(pcct_pkg::MS_PER_SEC);
    assign quarter_ms = base_ms >> 2;

    always_comb begin
        n_want   = r_want;
        n_told   = r_told;
        n_settle = r_settle;
        n_fail   = r_fail;
        n_halted = r_halted;
        n_fast   = r_fast;
        n_out    = '0;
        fire     = 1'b0;
        case (i_item.kind)
            pcct_pkg::K_START: begin
                n_halted = 1'b0;
                if (!r_want.online) begin
                    n_want.online = 1'b1;
                    n_settle      = i_cfg.settle_polls;
                end
            end
            pcct_pkg::K_STOP: begin
                n_halted = 1'b1;
            end
            pcct_pkg::K_SET_FREQ: begin
                if (r_want.freq != got.freq ||
                    (got.mode != '0 && r_want.mode != got.mode)) begin
                    n_want.freq = got.freq;
                    if (got.mode != '0) begin
                        n_want.mode = got.mode;
                    end
                    n_settle = i_cfg.settle_polls;
                end
            end
            pcct_pkg::K_SET_TX: begin
                if (r_want.tx_freq != got.tx_freq) begin
                    n_want.tx_freq = got.tx_freq;
                    n_want.split   = (got.tx_freq != '0);
                    n_settle       = i_cfg.settle_polls;
                end
            end
            pcct_pkg::K_SET_MODE: begin
                if (got.mode != '0 && r_want.mode != got.mode) begin
                    n_want.mode = got.mode;
                    n_settle    = i_cfg.settle_polls;
                end
            end
            pcct_pkg::K_SET_PTT: begin
                if (r_want.ptt != got.ptt) begin
                    n_want.ptt = got.ptt;
                    n_settle   = i_cfg.settle_polls;
                    if (!r_halted) begin
                        n_out.extra = 1'b1;
                        n_fast      = got.ptt;
                    end
                end
            end
            pcct_pkg::K_POLL_OK: begin
                if (!r_halted) begin
                    n_fail = '0;
                    if (r_settle != '0) begin
                        n_settle = settle_dec;
                        fire     = (got == r_want) || (settle_dec == '0);
                    end else begin
                        fire     = (got != r_told);
                    end
                    if (fire) begin
                        n_settle  = '0;
                        n_want    = got;
                        n_told    = got;
                        n_out.upd = 1'b1;
                    end
                end
            end
            default: begin
                if (!r_halted) begin
                    if (fail_inc < limit) begin
                        n_fail    = fail_inc;
                        n_out.tol = 1'b1;
                    end else begin
                        n_fail     = '0;
                        n_out.offl = 1'b1;
                    end
                end
            end
        endcase
        n_out.fast = n_fast;
        if (!n_fast) begin
            n_out.ms = base_ms;
        end else if (quarter_ms < pcct_pkg::FAST_MIN_MS) begin
            n_out.ms = pcct_pkg::FAST_MIN_MS;
        end else begin
            n_out.ms = quarter_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_want      <= '0;
            r_told      <= '0;
            r_settle    <= '0;
            r_fail      <= '0;
            r_halted    <= 1'b1;
            r_fast      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_want   <= n_want;
                r_told   <= n_told;
                r_settle <= n_settle;
                r_fail   <= n_fail;
                r_halted <= n_halted;
                r_fast   <= n_fast;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

/* rtl/core/poll_change_confirmation_tracker_unit.sv */
// poll_change_confirmation_tracker_unit: top level; APB register file,
// front decoder, item queue and state back end. Depends on pcct_pkg,
// pcct_front, pcct_queue, pcct_back.
// Path: the result word is registered through the front register, the queue and
// the result register. Throughput: one word per cycle while m_axis_tready is not held low.
// Reset: synchronous, clears state (halted, offline) and loads register defaults.
module poll_change_confirmation_tracker_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // freq, tx_freq, mode, ptt, split, online, transient
    input  logic [pcct_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    // func
    input  logic [pcct_pkg::FUNC_BITS-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // update_signal, offline_report, failure_tolerated, extra_polls,
    // fast_mode, interval_ms
    output logic [pcct_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [3:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    pcct_pkg::t_cfg  r_cfg;
    pcct_pkg::t_item front_item;
    pcct_pkg::t_item queue_item;
    logic            front_valid;
    logic            queue_ready;
    logic            queue_valid;
    logic            back_pop;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_seconds  <= pcct_pkg::POLL_SECONDS_RST;
            r_cfg.settle_polls  <= pcct_pkg::SETTLE_POLLS_RST;
            r_cfg.generic_tol   <= pcct_pkg::GENERIC_TOL_RST;
            r_cfg.transient_tol <= pcct_pkg::TRANSIENT_TOL_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                pcct_pkg::REG_POLL_SECONDS: r_cfg.poll_seconds  <= pwdata[15:0];
                pcct_pkg::REG_SETTLE_POLLS: r_cfg.settle_polls  <= pwdata[3:0];
                pcct_pkg::REG_GENERIC_TOL:  r_cfg.generic_tol   <= pwdata[3:0];
                default:                    r_cfg.transient_tol <= pwdata[3:0];
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            pcct_pkg::REG_POLL_SECONDS: prdata = {16'd0, r_cfg.poll_seconds};
            pcct_pkg::REG_SETTLE_POLLS: prdata = {28'd0, r_cfg.settle_polls};
            pcct_pkg::REG_GENERIC_TOL:  prdata = {28'd0, r_cfg.generic_tol};
            default:                    prdata = {28'd0, r_cfg.transient_tol};
        endcase
    end

    pcct_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_valid       (front_valid),
        .i_ready       (queue_ready),
        .o_item        (front_item)
    );

    pcct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .o_ready (queue_ready),
        .i_item  (front_item),
        .o_valid (queue_valid),
        .i_pop   (back_pop),
        .o_item  (queue_item)
    );

    pcct_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (queue_valid),
        .o_pop         (back_pop),
        .i_item        (queue_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* rtl/core/pcct_checker.sv */
// pcct_checker: port-level assertions for the tracker top level, bound to it
// below. Depends on pcct_pkg and poll_change_confirmation_tracker_unit.
module pcct_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [pcct_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

    logic [pcct_pkg::MS_BITS-1:0] ms;
    assign ms = m_axis_tdata[pcct_pkg::OUT_MS_LO +: pcct_pkg::MS_BITS];

    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result word changed");

    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($countones({m_axis_tdata[pcct_pkg::OUT_UPD],
                                       m_axis_tdata[pcct_pkg::OUT_OFFL],
                                       m_axis_tdata[pcct_pkg::OUT_TOL]}) <= 1))
        else $error("more than one poll outcome flagged");

    a_fast_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (ms >= pcct_pkg::FAST_MIN_MS))
        else $error("interval below fast floor");

    a_slow_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[pcct_pkg::OUT_FAST]) |->
            (ms >= pcct_pkg::MS_BITS'(pcct_pkg::MS_PER_SEC)))
        else $error("normal interval below one second");

endmodule

bind poll_change_confirmation_tracker_unit pcct_checker u_pcct_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* verif/tb_poll_change_confirmation_tracker_unit.sv */
// Testbench for poll_change_confirmation_tracker_unit: drives command and poll words
// on the stream input; checks every report against a local tracker model or a typed row's result.
// Depends on pcct_pkg and the RTL of the block only.
module tb_poll_change_confirmation_tracker_unit;
    import pcct_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int WORDS_PER_PHASE = 150;
    localparam int PHASES          = 8;
    localparam logic [FREQ_BITS-1:0] FMAX = '1;

    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic [FREQ_BITS-1:0] freq;
        logic [FREQ_BITS-1:0] tx;
        logic [MODE_BITS-1:0] mode;
        logic                 ptt;
        logic                 split;
        logic                 online;
        logic                 trans;
        logic                 typed;
        t_result              res;
    } t_row;

    localparam t_result RES_NONE       = '0;
    localparam t_result RES_1S         = '{0, 0, 0, 0, 0, 26'd1000};
    localparam t_result RES_EXTRA_1S   = '{0, 0, 0, 1, 0, 26'd1000};
    localparam t_result RES_EXTRA_FAST = '{0, 0, 0, 1, 1, 26'd250};
    localparam t_result RES_TOL_FAST   = '{0, 0, 1, 0, 1, 26'd250};
    localparam t_result RES_OFFL_FAST  = '{0, 1, 0, 0, 1, 26'd250};
    localparam t_result RES_FAST       = '{0, 0, 0, 0, 1, 26'd250};

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata;   // freq, tx_freq, mode, ptt, split, online, transient
    logic [FUNC_BITS-1:0]     s_axis_tuser;   // func
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;   // update, offline, tolerated, extra, fast, ms
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [3:0]               paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;

    poll_change_confirmation_tracker_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // tracker model state
    t_cfg        cfg_m;
    t_view       want_v;
    t_view       told_v;
    logic [3:0]  settle_left;
    logic [3:0]  fail_cnt;
    logic        halted;
    logic        fast_tx;

    t_result     expected_reports[$];
    t_row        dir_rows[25];
    t_cfg        phase_cfg[5];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          sink_stall = 0;
    int          hold_request = 0;
    bit          src_idle = 1'b0;
    bit          sink_idle = 1'b0;

    function automatic logic [MS_BITS-1:0] interval_now();
        int unsigned b;
        int unsigned q;
        b = (cfg_m.poll_seconds == 0) ? 1000 : cfg_m.poll_seconds * 1000;
        q = b / 4;
        if (!fast_tx)
            return b[MS_BITS-1:0];
        if (q < 250)
            q = 250;
        if (q > b)
            q = b;
        return q[MS_BITS-1:0];
    endfunction

    function automatic t_result track_poll_event(input t_row w);
        t_view               got;
        t_result             r;
        logic                fire;
        logic [CNT_BITS-1:0] lim;
        got = '{w.freq, w.tx, w.mode, w.ptt, w.split, w.online};
        r = RES_NONE;
        case (w.func)
            FUNC_START: begin
                halted = 1'b0;
                if (!want_v.online) begin
                    want_v.online = 1'b1;
                    settle_left = cfg_m.settle_polls;
                end
            end
            FUNC_STOP: halted = 1'b1;
            FUNC_SET_FREQ: begin
                if (want_v.freq != got.freq || (got.mode != 0 && want_v.mode != got.mode)) begin
                    want_v.freq = got.freq;
                    if (got.mode != 0)
                        want_v.mode = got.mode;
                    settle_left = cfg_m.settle_polls;
                end
            end
            FUNC_SET_TX: begin
                if (want_v.tx_freq != got.tx_freq) begin
                    want_v.tx_freq = got.tx_freq;
                    want_v.split = (got.tx_freq != 0);
                    settle_left = cfg_m.settle_polls;
                end
            end
            FUNC_SET_MODE: begin
                if (got.mode != 0 && want_v.mode != got.mode) begin
                    want_v.mode = got.mode;
                    settle_left = cfg_m.settle_polls;
                end
            end
            FUNC_SET_PTT: begin
                if (want_v.ptt != got.ptt) begin
                    want_v.ptt = got.ptt;
                    settle_left = cfg_m.settle_polls;
                    if (!halted) begin
                        r.extra = 1'b1;
                        fast_tx = got.ptt;
                    end
                end
            end
            FUNC_POLL_OK: begin
                if (!halted) begin
                    fire = 1'b0;
                    fail_cnt = '0;
                    if (settle_left != 0) begin
                        settle_left = settle_left - 4'd1;
                        if (got == want_v || settle_left == 0)
                            fire = 1'b1;
                    end else if (got != told_v) begin
                        fire = 1'b1;
                    end
                    if (fire) begin
                        settle_left = '0;
                        want_v = got;
                        told_v = got;
                        r.upd = 1'b1;
                    end
                end
            end
            default: begin
                if (!halted) begin
                    lim = w.trans ? cfg_m.transient_tol : cfg_m.generic_tol;
                    fail_cnt = fail_cnt + 4'd1;
                    if (fail_cnt < lim) begin
                        r.tol = 1'b1;
                    end else begin
                        fail_cnt = '0;
                        r.offl = 1'b1;
                    end
                end
            end
        endcase
        r.fast = fast_tx;
        r.ms = interval_now();
        return r;
    endfunction

    function automatic logic [FREQ_BITS-1:0] rand_freq();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        case ($urandom_range(0, 5))
            0: return '0;
            1: return FMAX;
            2, 3: return r[FREQ_BITS-1:0];
            4: return want_v.freq;
            default: return FREQ_BITS'($urandom_range(0, 3));
        endcase
    endfunction

    // mostly polls that confirm or track the expected state, plus commands and noise
    function automatic t_row random_word();
        t_row w;
        int   pick;
        int   k;
        w = '0;
        w.freq = rand_freq();
        w.tx = rand_freq();
        w.mode = MODE_BITS'($urandom_range(0, 15));
        w.ptt = 1'($urandom_range(0, 1));
        w.split = 1'($urandom_range(0, 1));
        w.online = 1'($urandom_range(0, 1));
        w.trans = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 5)       w.func = FUNC_START;
        else if (pick < 7)  w.func = FUNC_STOP;
        else if (pick < 15) w.func = FUNC_SET_FREQ;
        else if (pick < 21) w.func = FUNC_SET_TX;
        else if (pick < 27) w.func = FUNC_SET_MODE;
        else if (pick < 35) w.func = FUNC_SET_PTT;
        else if (pick < 70) w.func = FUNC_POLL_OK;
        else                w.func = FUNC_POLL_FAIL;
        if (halted && $urandom_range(0, 1) == 0)
            w.func = FUNC_START;
        if (w.func == FUNC_POLL_OK) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                {w.freq, w.tx, w.mode, w.ptt, w.split, w.online} = want_v;
            else if (pick < 7)
                {w.freq, w.tx, w.mode, w.ptt, w.split, w.online} = told_v;
            if (pick == 4) begin
                k = $urandom_range(0, FREQ_BITS - 1);
                w.freq[k] = ~w.freq[k];
            end
        end
        return w;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_POLL_SECONDS: cfg_m.poll_seconds = val[SEC_BITS-1:0];
            REG_SETTLE_POLLS: cfg_m.settle_polls = val[CNT_BITS-1:0];
            REG_GENERIC_TOL:  cfg_m.generic_tol = val[CNT_BITS-1:0];
            default:          cfg_m.transient_tol = val[CNT_BITS-1:0];
        endcase
    endtask

    task automatic offer_word(input t_row w);
        logic [IN_DATA_BITS-1:0] d;
        t_result                 p;
        d = '0;
        d[IN_FREQ_LO +: FREQ_BITS] = w.freq;
        d[IN_TX_LO +: FREQ_BITS] = w.tx;
        d[IN_MODE_LO +: MODE_BITS] = w.mode;
        d[IN_PTT] = w.ptt;
        d[IN_SPLIT] = w.split;
        d[IN_ONLINE] = w.online;
        d[IN_TRANS] = w.trans;
        s_axis_tdata <= d;
        s_axis_tuser <= w.func;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        p = track_poll_event(w);
        expected_reports.push_back(w.typed ? w.res : p);
        if (src_idle && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            $error("%s: expected %0d, actual %0d", name, e, a);
            mismatches++;
        end
    endtask

    task automatic check_report();
        t_result exp_r;
        if (expected_reports.size() == 0) begin
            $error("report word with nothing expected: %h", m_axis_tdata);
            mismatches++;
            return;
        end
        exp_r = expected_reports.pop_front();
        compare_field("update_signal", 32'(exp_r.upd), 32'(m_axis_tdata[OUT_UPD]));
        compare_field("offline_report", 32'(exp_r.offl), 32'(m_axis_tdata[OUT_OFFL]));
        compare_field("failure_tolerated", 32'(exp_r.tol), 32'(m_axis_tdata[OUT_TOL]));
        compare_field("extra_polls", 32'(exp_r.extra), 32'(m_axis_tdata[OUT_EXTRA]));
        compare_field("fast_mode", 32'(exp_r.fast), 32'(m_axis_tdata[OUT_FAST]));
        compare_field("interval_ms", 32'(exp_r.ms),
                      32'(m_axis_tdata[OUT_MS_LO +: MS_BITS]));
    endtask

    // result side: checking and back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_report();
            if (hold_request != 0) begin
                sink_stall = hold_request;
                hold_request = 0;
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_axis_tready <= 1'b0;
            end else if (sink_idle && $urandom_range(0, 7) == 0) begin
                sink_stall = $urandom_range(1, 12) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= FUNC_START;
        m_axis_tready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;

        cfg_m = '{POLL_SECONDS_RST, SETTLE_POLLS_RST, GENERIC_TOL_RST, TRANSIENT_TOL_RST};
        want_v = '0;
        told_v = '0;
        settle_left = '0;
        fail_cnt = '0;
        halted = 1'b1;
        fast_tx = 1'b0;

        // func, freq, tx, mode, ptt, split, online, transient, typed, result
        dir_rows = '{
            '{FUNC_POLL_OK,   FMAX, FMAX, 4'd15, 1, 1, 1, 1, 1, RES_1S},
            '{FUNC_POLL_FAIL, 0,    0,    4'd0,  0, 0, 0, 0, 1, RES_1S},
            '{FUNC_SET_PTT,   0,    0,    4'd0,  1, 0, 0, 0, 1, RES_1S},
            '{FUNC_START,     0,    0,    4'd0,  0, 0, 0, 0, 1, RES_1S},
            '{FUNC_SET_PTT,   0,    0,    4'd0,  0, 0, 0, 0, 1, RES_EXTRA_1S},
            '{FUNC_SET_PTT,   0,    0,    4'd0,  1, 0, 0, 0, 1, RES_EXTRA_FAST},
            '{FUNC_SET_FREQ,  FMAX, 0,    4'd15, 0, 0, 0, 0, 0, RES_NONE},
            '{FUNC_SET_TX,    0,    FMAX, 4'd0,  0, 0, 0, 0, 0, RES_NONE},
            '{FUNC_SET_MODE,  0,    0,    4'd0,  0, 0, 0, 0, 0, RES_NONE},
            '{FUNC_SET_MODE,  0,    0,    4'd9,  0, 0, 0, 0, 0, RES_NONE},
            '{FUNC_POLL_OK,   FMAX, FMAX, 4'd9,  1, 1, 1, 0, 0, RES_NONE},
            '{FUNC_POLL_OK,   FMAX, FMAX, 4'd9,  1, 1, 1, 0, 0, RES_NONE},
            '{FUNC_POLL_OK,   0,    FMAX, 4'd9,  1, 1, 1, 0, 0, RES_NONE},
            '{FUNC_POLL_FAIL, 0,    0,    4'd0,  0, 0, 0, 0, 1, RES_TOL_FAST},
            '{FUNC_POLL_FAIL, 0,    0,    4'd0,  0, 0, 0, 0, 1, RES_TOL_FAST},
            '{FUNC_POLL_FAIL, 0,    0,    4'd0,  0, 0, 0, 0, 1, RES_OFFL_FAST},
            '{FUNC_POLL_FAIL, 0,    0,    4'd0,  0, 0, 0, 1, 0, RES_NONE},
            '{FUNC_POLL_FAIL, FMAX, FMAX, 4'd15, 1, 1, 1, 1, 0, RES_NONE},
            '{FUNC_STOP,      0,    0,    4'd0,  0, 0, 0, 0, 0, RES_NONE},
            '{FUNC_SET_PTT,   0,    0,    4'd0,  0, 0, 0, 0, 1, RES_FAST},
            '{FUNC_POLL_OK,   0,    0,    4'd1,  0, 0, 0, 0, 0, RES_NONE},
            '{FUNC_START,     0,    0,    4'd0,  0, 0, 0, 0, 0, RES_NONE},
            '{FUNC_POLL_OK,   0,    0,    4'd0,  0, 0, 0, 0, 0, RES_NONE},
            '{FUNC_SET_TX,    0,    0,    4'd0,  0, 0, 0, 0, 0, RES_NONE},
            '{FUNC_SET_FREQ,  0,    0,    4'd0,  0, 0, 0, 0, 0, RES_NONE}
        };

        // zero settle and zero tolerances included on purpose
        phase_cfg = '{
            '{16'd0,     4'd1,  4'd1,  4'd1},
            '{16'hffff,  4'd15, 4'd15, 4'd15},
            '{16'd3,     4'd0,  4'd0,  4'd0},
            '{16'd1,     4'd2,  4'd2,  4'd15},
            '{16'd2,     4'd3,  4'd3,  4'd8}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle = 1'b1;
        sink_idle = 1'b1;
        foreach (dir_rows[i])
            offer_word(dir_rows[i]);

        for (int ph = 0; ph < PHASES; ph++) begin
            s_axis_tvalid <= 1'b0;
            while (expected_reports.size() != 0)
                @(posedge i_clk);
            repeat (4) @(posedge i_clk);
            if (ph >= 4 && ph < 7) begin
                write_reg(REG_POLL_SECONDS, $urandom_range(0, 65535));
                write_reg(REG_SETTLE_POLLS, $urandom_range(0, 15));
                write_reg(REG_GENERIC_TOL, $urandom_range(0, 15));
                write_reg(REG_TRANSIENT_TOL, $urandom_range(0, 15));
            end else begin
                write_reg(REG_POLL_SECONDS, 32'(phase_cfg[ph % 5].poll_seconds));
                write_reg(REG_SETTLE_POLLS, 32'(phase_cfg[ph % 5].settle_polls));
                write_reg(REG_GENERIC_TOL, 32'(phase_cfg[ph % 5].generic_tol));
                write_reg(REG_TRANSIENT_TOL, 32'(phase_cfg[ph % 5].transient_tol));
            end
            // stretches without gaps, and none at all at the end
            src_idle = !(ph == 1 || ph == 5 || ph == PHASES - 1);
            sink_idle = src_idle;
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (ph == 2 && n == 50)
                    hold_request = 300;
                offer_word(random_word());
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* poll_change_confirmation_tracker_unit.f */
rtl/core/pcct_pkg.sv
rtl/core/pcct_front.sv
rtl/core/pcct_queue.sv
rtl/core/pcct_back.sv
rtl/core/poll_change_confirmation_tracker_unit.sv
rtl/core/pcct_checker.sv
verif/tb_poll_change_confirmation_tracker_unit.sv
